// ===== hdl/jsu_pkg.sv =====
// jsu_pkg: shared types, character codes and decode helpers for the json string unescaper
// used by jsu_decode, jsu_emit and the top level; no dependencies
package jsu_pkg;

    // scanner modes; the two unused codes of the 3-bit field decode as plain text
    typedef enum logic [2:0] {
        MODE_PLAIN      = 3'd0,
        MODE_ESC        = 3'd1,
        MODE_HEX1       = 3'd2,
        MODE_HI_WAIT_BS = 3'd3,
        MODE_HI_WAIT_U  = 3'd4,
        MODE_HEX2       = 3'd5
    } mode_t;

    // result kind carried with every word
    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_OK     = 2'd1,
        KIND_UNTERM = 2'd2
    } kind_t;

    // group of up to four result words caused by one input byte
    typedef struct packed {
        logic [2:0]      cnt;
        kind_t           kind;
        logic [0:3][7:0] bytes;
    } grp_t;

    // outcome of the plain-text and escape handlers
    typedef struct packed {
        mode_t mode;
        logic  clear;
        logic  start;
        grp_t  grp;
    } step_t;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LC_B   = 8'h62;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_U   = 8'h75;

    localparam logic [15:0] HI_SURR_LO = 16'hD800;
    localparam logic [15:0] HI_SURR_HI = 16'hDBFF;
    localparam logic [15:0] LO_SURR_LO = 16'hDC00;
    localparam logic [15:0] LO_SURR_HI = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE  = 21'h10000;

    function automatic grp_t grp_one(input logic [7:0] b);
        grp_t g;
        g          = '0;
        g.cnt      = 3'd1;
        g.kind     = KIND_DATA;
        g.bytes[0] = b;
        return g;
    endfunction

    function automatic grp_t grp_end(input kind_t k);
        grp_t g;
        g      = '0;
        g.cnt  = 3'd1;
        g.kind = k;
        return g;
    endfunction

    // {valid, value} of a hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        r = '0;
        if (b inside {[8'h30:8'h39]}) begin
            r = {1'b1, b[3:0]};
        end
        else if (b inside {[8'h61:8'h66]} || b inside {[8'h41:8'h46]}) begin
            r = {1'b1, b[3:0] + 4'd9};
        end
        return r;
    endfunction

    // utf-8 encoding of a code point up to 21 bits
    function automatic grp_t utf8_enc(input logic [20:0] cp);
        grp_t g;
        g      = '0;
        g.kind = KIND_DATA;
        if (cp < 21'h80) begin
            g.cnt      = 3'd1;
            g.bytes[0] = cp[7:0];
        end
        else if (cp < 21'h800) begin
            g.cnt      = 3'd2;
            g.bytes[0] = {3'b110, cp[10:6]};
            g.bytes[1] = {2'b10, cp[5:0]};
        end
        else if (cp < 21'h10000) begin
            g.cnt      = 3'd3;
            g.bytes[0] = {4'b1110, cp[15:12]};
            g.bytes[1] = {2'b10, cp[11:6]};
            g.bytes[2] = {2'b10, cp[5:0]};
        end
        else begin
            g.cnt      = 3'd4;
            g.bytes[0] = {5'b11110, cp[20:18]};
            g.bytes[1] = {2'b10, cp[17:12]};
            g.bytes[2] = {2'b10, cp[11:6]};
            g.bytes[3] = {2'b10, cp[5:0]};
        end
        return g;
    endfunction

    // byte outside any escape
    function automatic step_t plain_step(input logic [7:0] b);
        step_t s;
        s      = '0;
        s.mode = MODE_PLAIN;
        if (b == CH_QUOTE) begin
            s.clear = 1'b1;
            s.grp   = grp_end(KIND_OK);
        end
        else if (b == CH_NUL) begin
            s.clear = 1'b1;
            s.grp   = grp_end(KIND_UNTERM);
        end
        else if (b == CH_BSLASH) begin
            s.mode = MODE_ESC;
        end
        else begin
            s.grp = grp_one(b);
        end
        return s;
    endfunction

    // byte after a backslash
    function automatic step_t escape_step(input logic [7:0] b);
        step_t s;
        s      = '0;
        s.mode = MODE_PLAIN;
        case (b)
            CH_NUL:
            begin
                s.clear = 1'b1;
                s.grp   = grp_end(KIND_UNTERM);
            end
            CH_LC_B: s.grp = grp_one(8'h08);
            CH_LC_F: s.grp = grp_one(8'h0C);
            CH_LC_N: s.grp = grp_one(8'h0A);
            CH_LC_R: s.grp = grp_one(8'h0D);
            CH_LC_T: s.grp = grp_one(8'h09);
            CH_LC_U:
            begin
                s.mode  = MODE_HEX1;
                s.start = 1'b1;
            end
            default: s.grp = grp_one(b);
        endcase
        return s;
    endfunction

endpackage

// ===== hdl/jsu_decode.sv =====
// jsu_decode: scanner state registers and the single-pass decode of one input byte
// depends on jsu_pkg
module jsu_decode (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    in_byte,
    output jsu_pkg::grp_t grp
);
    import jsu_pkg::*;

    mode_t       mode_reg,    mode_next;
    logic [15:0] accum_reg,   accum_next;
    logic [2:0]  count_reg,   count_next;
    logic        stopped_reg, stopped_next;
    logic [9:0]  high_reg,    high_next;

    logic [4:0]  hex;
    logic [15:0] acc_f;
    logic        stop_f;
    logic [2:0]  cnt_f;
    logic        done;
    step_t       st;
    logic        use_st;

    // hex group feed
    always_comb
    begin
        hex    = hex_digit(in_byte);
        acc_f  = accum_reg;
        if (!stopped_reg && hex[4]) begin
            acc_f = {accum_reg[11:0], hex[3:0]};
        end
        stop_f = stopped_reg | ~hex[4];
        cnt_f  = count_reg + 3'd1;
        done   = (cnt_f >= 3'd4);
    end

    always_comb
    begin
        mode_next    = mode_reg;
        accum_next   = accum_reg;
        count_next   = count_reg;
        stopped_next = stopped_reg;
        high_next    = high_reg;
        grp          = '0;
        st           = '0;
        use_st       = 1'b0;

        case (mode_reg)
            MODE_ESC:
            begin
                st     = escape_step(in_byte);
                use_st = 1'b1;
            end
            MODE_HEX1, MODE_HEX2:
            begin
                if (in_byte == CH_NUL) begin
                    st     = plain_step(in_byte);
                    use_st = 1'b1;
                end
                else begin
                    accum_next   = acc_f;
                    stopped_next = stop_f;
                    count_next   = cnt_f;
                    if (done) begin
                        mode_next = MODE_PLAIN;
                        if (mode_reg == MODE_HEX1) begin
                            if (acc_f == 16'h0000
                                || acc_f inside {[LO_SURR_LO:LO_SURR_HI]}) begin
                                grp = '0;
                            end
                            else if (acc_f inside {[HI_SURR_LO:HI_SURR_HI]}) begin
                                high_next = acc_f[9:0];
                                mode_next = MODE_HI_WAIT_BS;
                            end
                            else begin
                                grp = utf8_enc({5'd0, acc_f});
                            end
                        end
                        else if (acc_f inside {[LO_SURR_LO:LO_SURR_HI]}) begin
                            grp = utf8_enc(SUPP_BASE + {1'b0, high_reg, acc_f[9:0]});
                        end
                    end
                end
            end
            MODE_HI_WAIT_BS:
            begin
                if (in_byte == CH_BSLASH) begin
                    mode_next = MODE_HI_WAIT_U;
                end
                else begin
                    st     = plain_step(in_byte);
                    use_st = 1'b1;
                end
            end
            MODE_HI_WAIT_U:
            begin
                if (in_byte == CH_LC_U) begin
                    st      = '0;
                    st.mode = MODE_HEX2;
                    st.start = 1'b1;
                end
                else begin
                    st = escape_step(in_byte);
                end
                use_st = 1'b1;
            end
            default:
            begin
                st     = plain_step(in_byte);
                use_st = 1'b1;
            end
        endcase

        if (use_st) begin
            mode_next = st.mode;
            grp       = st.grp;
            if (st.clear) begin
                accum_next   = '0;
                count_next   = '0;
                stopped_next = 1'b0;
                high_next    = '0;
            end
            if (st.start) begin
                accum_next   = '0;
                count_next   = '0;
                stopped_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg    <= MODE_PLAIN;
            accum_reg   <= '0;
            count_reg   <= '0;
            stopped_reg <= 1'b0;
            high_reg    <= '0;
        end
        else if (accept) begin
            mode_reg    <= mode_next;
            accum_reg   <= accum_next;
            count_reg   <= count_next;
            stopped_reg <= stopped_next;
            high_reg    <= high_next;
        end
    end

endmodule

// ===== hdl/jsu_emit.sv =====
// jsu_emit: group register and output serializer, one word per handshake
// depends on jsu_pkg
module jsu_emit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  jsu_pkg::grp_t grp_in,
    output logic          can_push,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_byte,
    output logic [1:0]    out_kind,
    output logic          run_last
);
    import jsu_pkg::*;

    grp_t       grp_reg;
    logic       grp_valid_reg;
    grp_t       cur_reg;
    logic       cur_valid_reg;
    logic [1:0] idx_reg;

    logic       last;
    logic       out_fire;
    logic       load;

    assign last     = ({1'b0, idx_reg} == (cur_reg.cnt - 3'd1));
    assign out_fire = cur_valid_reg && out_ready;
    assign load     = grp_valid_reg && (!cur_valid_reg || (out_fire && last));
    assign can_push = !grp_valid_reg || load;

    assign out_valid = cur_valid_reg;
    assign out_byte  = cur_reg.bytes[idx_reg];
    assign out_kind  = cur_reg.kind;
    assign run_last  = last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            grp_valid_reg <= 1'b0;
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else begin
            if (push) begin
                grp_valid_reg <= 1'b1;
            end
            else if (load) begin
                grp_valid_reg <= 1'b0;
            end

            if (load) begin
                cur_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end
            else if (out_fire && last) begin
                cur_valid_reg <= 1'b0;
            end
            else if (out_fire) begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            grp_reg <= grp_in;
        end
        if (load) begin
            cur_reg <= grp_reg;
        end
    end

endmodule

// ===== hdl/json_string_unescape_utf8.sv =====
// json_string_unescape_utf8: streaming json string-body unescaper with utf-8 output
// output path: a byte's result group is registered in the group register, then in the serializer
// throughput: 1 byte per cycle while each byte gives at most one word and the output
//   is not stalled; a multi-word group (up to 4, a full code point) goes out word by word
// reset: rst_n async active low, scanner returns to plain text, no word pending
// depends on jsu_pkg, jsu_decode, jsu_emit
module json_string_unescape_utf8 (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic [1:0] out_kind,
    output logic       run_last
);
    import jsu_pkg::*;

    // byte accepted this edge
    logic accept;
    // result group decoded from the byte at the input
    grp_t grp;
    // group register can take a group this cycle
    logic can_push;
    // only bytes that give at least one word go into the group register
    logic push;

    // a byte is taken whenever the group register has room, including the
    // cycle in which it moves its group on to the serializer; the serializer
    // keeps the current word, so a stalled output does not stop the input
    // until a second group is waiting
    assign in_ready = can_push;
    assign accept   = in_valid && in_ready;
    assign push     = accept && (grp.cnt != 3'd0);

    // scanner: escape, hex group and surrogate pair tracking, utf-8 encode
    jsu_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (in_byte),
        .grp     (grp)
    );

    // group register and word serializer; run_last marks the final word
    // of the group a byte caused
    jsu_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .grp_in    (grp),
        .can_push  (can_push),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .out_kind  (out_kind),
        .run_last  (run_last)
    );

endmodule

// ===== hdl/jsu_port_check.sv =====
// jsu_port_check: port-level assertions for json_string_unescape_utf8, bound to the top level
// depends on jsu_pkg and json_string_unescape_utf8
module jsu_port_check (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic [1:0] out_kind,
    input logic       run_last
);
    import jsu_pkg::*;

    // a stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte)
            && $stable(out_kind) && $stable(run_last))
        else $error("output word changed while stalled");

    // end-of-string marks stand alone and carry a zero byte
    a_end_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind != KIND_DATA |-> run_last && out_byte == 8'h00)
        else $error("end mark not a lone zero word");

    // kind stays within the defined codes
    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_kind <= KIND_UNTERM)
        else $error("bad output kind");

    // the rest of a multi-word group follows without a gap
    a_group_tight: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !run_last |=> out_valid)
        else $error("gap inside a word group");

    // a word that continues a group is a utf-8 continuation byte
    a_cont_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !run_last |=> out_byte[7:6] == 2'b10)
        else $error("continuation word is not 10xxxxxx");

endmodule

bind json_string_unescape_utf8 jsu_port_check u_port_check (.*);
